[sv/msws_range_random_defines.svh]
// ----------------------------------------------------------------------------
// msws_range_random_defines.svh
// Assertion macros shared by the range random generator.
// ----------------------------------------------------------------------------
`ifndef MSWS_RANGE_RANDOM_DEFINES_SVH
`define MSWS_RANGE_RANDOM_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define MSWS_RR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define MSWS_RR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/msws_rr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msws_rr_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package msws_rr_pkg;

    localparam int DATA_W = 32;
    localparam int WORD_W = 64;
    localparam int APB_AW = 4;
    localparam int CNT_W  = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] WEYL_RESET = 64'hB5AD_4ECE_DA1C_E2A9;
    localparam logic [DATA_W-1:0] FRAC_MOD   = 32'hFFFF_FFFF;

    // register index taken from paddr[3]
    localparam logic REG_WEYL_INC = 1'b0;

    localparam logic OP_INT  = 1'b0;
    localparam logic OP_FRAC = 1'b1;

    typedef struct packed {
        logic load;
        logic mul_sq;
        logic mul_cross;
        logic mix;
        logic fold;
        logic mul_frac;
        logic scale;
        logic div_start;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic err;
        logic op;
        logic div_busy;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

[sv/msws_rr_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msws_rr_div
// Restoring divider, one bit per cycle, remainder of 64-bit by 32-bit.
// ----------------------------------------------------------------------------
module msws_rr_div
    import msws_rr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic [DATA_W-1:0] remainder,
    output logic              busy,
    output logic              done
);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dq_reg, dq_next;
    logic [DATA_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] trial;
    logic              fits;

    always_comb begin
        shifted  = {rem_reg, dq_reg[WORD_W-1]};
        trial    = {1'b0, shifted} - {2'b00, dvs_reg};
        fits     = !trial[DATA_W+1];
        rem_next = fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
        dq_next  = {dq_reg[WORD_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WORD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dq_reg  <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign remainder = rem_reg;
    assign busy      = busy_reg;
    assign done      = done_reg;

endmodule

[sv/msws_rr_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msws_rr_dp
// Generator state, shared 32x32 multiplier, divider and result register.
// ----------------------------------------------------------------------------
module msws_rr_dp
    import msws_rr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic [WORD_W-1:0] weyl_inc,
    input  logic              in_op,
    input  logic [DATA_W-1:0] in_low,
    input  logic [DATA_W-1:0] in_high,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_value,
    output logic              out_err
);

    logic [WORD_W-1:0] weyl_reg;
    logic [WORD_W-1:0] mix_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] acc_reg;
    logic              op_reg;
    logic [DATA_W-1:0] low_reg;
    logic [DATA_W-1:0] diff_reg;
    logic              err_reg;
    logic [DATA_W-1:0] frac_reg;
    logic [DATA_W-1:0] scale_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_err_reg;

    logic [DATA_W:0]   span;
    logic [DATA_W-1:0] mul_a, mul_b;
    logic [WORD_W-1:0] product;
    logic [WORD_W-1:0] mixed;
    logic [DATA_W:0]   fold_sum;
    logic [DATA_W-1:0] fold_red;
    logic [DATA_W:0]   fq_sum;
    logic [1:0]        fq_adj;
    logic [DATA_W-1:0] frac_quo;
    logic [DATA_W-1:0] div_rem;
    logic              div_busy, div_done;
    logic [DATA_W-1:0] offset;

    always_comb begin
        span = {in_high[DATA_W-1], in_high} - {in_low[DATA_W-1], in_low};

        mul_a = mix_reg[DATA_W-1:0];
        mul_b = mix_reg[DATA_W-1:0];
        if (cmd.mul_cross) begin
            mul_b = mix_reg[WORD_W-1:DATA_W];
        end else if (cmd.mul_frac) begin
            mul_a = frac_reg;
            mul_b = diff_reg;
        end
        product = {{DATA_W{1'b0}}, mul_a} * {{DATA_W{1'b0}}, mul_b};

        // cross term counts twice: shift by 33
        mixed = acc_reg + {prod_reg[DATA_W-2:0], {(DATA_W+1){1'b0}}};

        // word mod (2^32 - 1) by end-around fold
        fold_sum = {1'b0, mix_reg[WORD_W-1:DATA_W]} + {1'b0, mix_reg[DATA_W-1:0]};
        fold_red = fold_sum[DATA_W-1:0] + {{(DATA_W-1){1'b0}}, fold_sum[DATA_W]};

        // p / (2^32 - 1) = p_hi + (p_hi + p_lo) / (2^32 - 1), the second term at most 2
        fq_sum = {1'b0, prod_reg[WORD_W-1:DATA_W]} + {1'b0, prod_reg[DATA_W-1:0]};
        if (fq_sum >= {FRAC_MOD, 1'b0}) begin
            fq_adj = 2'd2;
        end else if (fq_sum >= {1'b0, FRAC_MOD}) begin
            fq_adj = 2'd1;
        end else begin
            fq_adj = 2'd0;
        end
        frac_quo = prod_reg[WORD_W-1:DATA_W] + {{(DATA_W-2){1'b0}}, fq_adj};

        offset = (op_reg == OP_FRAC) ? scale_reg : div_rem;
    end

    msws_rr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (mix_reg),
        .divisor   (diff_reg),
        .remainder (div_rem),
        .busy      (div_busy),
        .done      (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weyl_reg <= '0;
            mix_reg  <= '0;
        end else begin
            if (cmd.load) begin
                weyl_reg <= weyl_reg + weyl_inc;
            end
            if (cmd.mix) begin
                mix_reg <= {mixed[DATA_W-1:0], mixed[WORD_W-1:DATA_W]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_op;
            low_reg  <= in_low;
            diff_reg <= span[DATA_W-1:0];
            err_reg  <= span[DATA_W] || (span == '0);
        end
        if (cmd.mul_sq || cmd.mul_cross || cmd.mul_frac) begin
            prod_reg <= product;
        end
        if (cmd.mul_cross) begin
            acc_reg <= prod_reg + weyl_reg;
        end
        if (cmd.fold) begin
            frac_reg <= (fold_red == FRAC_MOD) ? '0 : fold_red;
        end
        if (cmd.scale) begin
            scale_reg <= frac_quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_value_reg <= err_reg ? low_reg : low_reg + offset;
            out_err_reg   <= err_reg;
        end
    end

    assign stat.err      = err_reg;
    assign stat.op       = op_reg;
    assign stat.div_busy = div_busy;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_err   = out_err_reg;

endmodule

[sv/msws_rr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msws_rr_ctrl
// Draw sequencer: mix, then fold and scale, or divide, or neither; then emit.
// ----------------------------------------------------------------------------
module msws_rr_ctrl
    import msws_rr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQ    = 4'd1;
    localparam logic [3:0] ST_CROSS = 4'd2;
    localparam logic [3:0] ST_MIX   = 4'd3;
    localparam logic [3:0] ST_FOLD  = 4'd4;
    localparam logic [3:0] ST_MULF  = 4'd5;
    localparam logic [3:0] ST_DIVS  = 4'd6;
    localparam logic [3:0] ST_DIVW  = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;
    localparam logic [3:0] ST_SCALE = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.mul_sq = 1'b1;
                state_next = ST_CROSS;
            end
            ST_CROSS: begin
                cmd.mul_cross = 1'b1;
                state_next    = ST_MIX;
            end
            ST_MIX: begin
                cmd.mix = 1'b1;
                if (stat.err) begin
                    state_next = ST_EMIT;
                end else if (stat.op == OP_FRAC) begin
                    state_next = ST_FOLD;
                end else begin
                    state_next = ST_DIVS;
                end
            end
            ST_FOLD: begin
                cmd.fold   = 1'b1;
                state_next = ST_MULF;
            end
            ST_MULF: begin
                cmd.mul_frac = 1'b1;
                state_next   = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_DIVS: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW: begin
                if (stat.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/msws_range_random.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msws_range_random
// Middle-square Weyl sequence generator with integer and Q16.16 range mapping.
//
//   channel  | dir | payload
//   s_axis   | in  | tdata: range_low, range_high; tuser: operation
//   m_axis   | out | tdata: value; tuser: range_error
//   apb      | in  | weyl_increment at byte address 0, 64-bit data
//
// Integer draws take their offset from the bit-serial divider, fraction draws
// theirs from the fold and scale steps. An empty or inverted range skips the
// mapping and emits range_low. One draw at a time.
// Reset (aresetn low, synchronous) clears the mixer state and Weyl counter
// and loads the default increment. A stalled result holds in the output
// register; the next beat is accepted meanwhile and finishes behind it.
// ----------------------------------------------------------------------------
`include "msws_range_random_defines.svh"

module msws_range_random
    import msws_rr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [2*DATA_W-1:0] s_axis_tdata,   // [31:0] range_low, [63:32] range_high
    input  logic [0:0]          s_axis_tuser,   // [0] operation

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [DATA_W-1:0]   m_axis_tdata,   // [31:0] value
    output logic [0:0]          m_axis_tuser,   // [0] range_error

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [WORD_W-1:0]   pwdata,
    output logic [WORD_W-1:0]   prdata,
    output logic                pready
);

    logic [WORD_W-1:0] weyl_inc_reg;
    cmd_t              cmd;
    stat_t             stat;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_WEYL_INC) ? weyl_inc_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weyl_inc_reg <= WEYL_RESET;
        end else if (psel && penable && pwrite && pready && paddr[3] == REG_WEYL_INC) begin
            weyl_inc_reg <= pwdata;
        end
    end

    msws_rr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    msws_rr_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .weyl_inc  (weyl_inc_reg),
        .in_op     (s_axis_tuser[0]),
        .in_low    (s_axis_tdata[DATA_W-1:0]),
        .in_high   (s_axis_tdata[2*DATA_W-1:DATA_W]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (m_axis_tdata),
        .out_err   (m_axis_tuser[0])
    );

    `MSWS_RR_ASSERT_NXT(a_one_draw, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second beat")
    `MSWS_RR_ASSERT_IMP(a_no_overwrite, cmd.emit, !m_axis_tvalid || m_axis_tready, "beat lost")
    `MSWS_RR_ASSERT_IMP(a_div_restart, cmd.div_start, !stat.div_busy, "divider restart")

endmodule

[dv/msws_range_random_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msws_range_random_test
// Self-checking bench for the middle-square Weyl range generator.
//
// A driver offers draw requests from a queue, a monitor accepts results under
// random backpressure. Each accepted request is run through a local model of
// the Weyl counter, the squared and rotated mixer state and the integer or
// Q16.16 range mapping; results are compared field by field in order. The
// increment register starts at its reset value and is rewritten between phases
// (zero, all ones, random odd and even words) while the block is idle.
// ----------------------------------------------------------------------------
module msws_range_random_test;
    import msws_rr_pkg::*;

    typedef struct packed {
        logic               op;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } draw_req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               err;
    } draw_res_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [2*DATA_W-1:0] s_axis_tdata = '0;     // [31:0] range_low, [63:32] range_high
    logic [0:0]          s_axis_tuser = '0;     // [0] operation
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   m_axis_tdata;          // [31:0] value
    logic [0:0]          m_axis_tuser;          // [0] range_error
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [WORD_W-1:0]   pwdata = '0;
    logic [WORD_W-1:0]   prdata;
    logic                pready;

    msws_range_random dut (.*);

    always #1 aclk = ~aclk;

    // model state
    logic [63:0] mix_state;
    logic [63:0] weyl_count;
    logic [63:0] weyl_inc;

    draw_req_t draw_requests[$];
    draw_res_t expected_draws[$];
    draw_req_t offered_draw;
    int        mismatch_count = 0;
    int        results_seen = 0;
    int        send_gap = 0;
    bit        send_calm = 1'b0;
    int        recv_stall = 0;
    int        recv_hold = 0;
    int        next_hold_at = 120;
    bit        recv_calm = 1'b0;

    function automatic draw_res_t map_next_draw(input draw_req_t req);
        logic [63:0]        sq;
        logic [63:0]        span64;
        logic [63:0]        frac_part;
        logic [63:0]        scaled;
        logic signed [32:0] span;
        draw_res_t          res;
        weyl_count = weyl_count + weyl_inc;
        sq = mix_state * mix_state + weyl_count;
        mix_state = {sq[31:0], sq[63:32]};
        span = {req.hi[31], req.hi} - {req.lo[31], req.lo};
        if (span <= 0) begin
            res.value = req.lo;
            res.err = 1'b1;
        end else begin
            span64 = {31'b0, span};
            if (req.op == OP_INT) begin
                scaled = mix_state % span64;
            end else begin
                frac_part = mix_state % {32'b0, FRAC_MOD};
                scaled = (frac_part * span64) / {32'b0, FRAC_MOD};
            end
            res.value = req.lo + scaled[31:0];
            res.err = 1'b0;
        end
        return res;
    endfunction

    function automatic int pick_gap(input bit calm);
        if (calm) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
        return $urandom_range(10, 60);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_draws = {expected_draws, map_next_draw(offered_draw)};
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (draw_requests.size() > 0) begin
                    offered_draw = draw_requests.pop_front();
                    s_axis_tdata <= {offered_draw.hi, offered_draw.lo};
                    s_axis_tuser <= offered_draw.op;
                    s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap(send_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        draw_res_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_draws.size() == 0) begin
                    $error("unexpected result beat: value %0d, range_error %0b",
                           $signed(m_axis_tdata), m_axis_tuser[0]);
                    mismatch_count++;
                end else begin
                    want = expected_draws.pop_front();
                    if (m_axis_tdata !== want.value) begin
                        $error("value: expected %0d, actual %0d",
                               want.value, $signed(m_axis_tdata));
                        mismatch_count++;
                    end
                    if (m_axis_tuser[0] !== want.err) begin
                        $error("range_error: expected %0b, actual %0b",
                               want.err, m_axis_tuser[0]);
                        mismatch_count++;
                    end
                end
            end
            if (recv_hold > 0) begin
                recv_hold--;
            end else if (recv_stall > 0) begin
                recv_stall--;
            end else if (results_seen >= next_hold_at) begin
                // hold off long enough for the block to fill and stall its input
                recv_hold = 500;
                next_hold_at += 330;
            end else if (!recv_calm && $urandom_range(0, 3) == 0) begin
                recv_stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                        : $urandom_range(20, 150);
            end
            m_axis_tready <= (recv_hold == 0 && recv_stall == 0);
        end
    end

    task automatic add_draw(input logic op, input logic signed [31:0] lo,
                            input logic signed [31:0] hi);
        draw_req_t req;
        req.op = op;
        req.lo = lo;
        req.hi = hi;
        draw_requests = {draw_requests, req};
    endtask

    task automatic add_random_draws(input int count);
        logic signed [31:0] a;
        logic signed [31:0] b;
        int                 kind;
        int                 span;
        for (int i = 0; i < count; i++) begin
            a = $urandom;
            b = $urandom;
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                add_draw(1'($urandom_range(0, 1)), a, b);
            end else if (kind == 2) begin
                add_draw(1'($urandom_range(0, 1)), (a > b) ? a : b, (a > b) ? b : a);
            end else if (kind < 6) begin
                span = $urandom_range(1, 1000);
                if (a > 32'sh7FFF_FFFF - span) a = 32'sh7FFF_FFFF - span;
                add_draw(1'($urandom_range(0, 1)), a, a + span);
            end else begin
                add_draw(1'($urandom_range(0, 1)), (a < b) ? a : b, (a < b) ? b : a);
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (draw_requests.size() != 0 || s_axis_tvalid || expected_draws.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_weyl_inc(input logic [63:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_WEYL_INC, 3'b000};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        weyl_inc = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        mix_state = '0;
        weyl_count = '0;
        weyl_inc = WEYL_RESET;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        add_draw(OP_INT, 0, 1);
        add_draw(OP_INT, 32'sh8000_0000, 32'sh7FFF_FFFF);
        add_draw(OP_FRAC, 32'sh8000_0000, 32'sh7FFF_FFFF);
        add_draw(OP_INT, 77, 77);
        add_draw(OP_INT, 32'sh7FFF_FFFF, 32'sh8000_0000);
        add_draw(OP_FRAC, 5, 5);
        add_draw(OP_FRAC, 32'sh0001_0000, -32'sh0001_0000);
        add_draw(OP_FRAC, 0, 32'sh0001_0000);
        add_draw(OP_FRAC, -32'sh0001_0000, 32'sh0001_0000);
        add_draw(OP_INT, 0, 32'sh7FFF_FFFF);
        add_draw(OP_INT, -100, 100);
        add_draw(OP_FRAC, 32'sh8000_0000, 32'sh8000_0001);
        add_draw(OP_INT, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF);
        add_draw(OP_INT, -1, 0);
        add_draw(OP_FRAC, 0, 32'sh7FFF_FFFF);
        add_draw(OP_INT, 0, 3);
        add_draw(OP_INT, 0, 256);
        add_draw(OP_INT, 0, 1000000007);
        add_draw(OP_FRAC, 32'sh8000_0000, 0);
        add_random_draws(150);
        wait_idle();

        write_weyl_inc(64'h0);
        add_random_draws(100);
        wait_idle();

        write_weyl_inc('1);
        add_random_draws(100);
        wait_idle();

        write_weyl_inc({$urandom, $urandom} | 64'h1);
        add_random_draws(150);
        wait_idle();

        write_weyl_inc({$urandom, $urandom} & ~64'h1);
        add_random_draws(100);
        wait_idle();

        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && expected_draws.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
